/* src/rdp_pkg.sv */
// ----------------------------------------------------------------------------
// rdp_pkg
// shared widths, constants and types of the base-10000 digit dot product
// ----------------------------------------------------------------------------
package rdp_pkg;

  // field and state widths
  localparam int DIGIT_W = 14;
  localparam int PROD_W  = 2 * DIGIT_W;
  localparam int SUM_W   = 32;
  localparam int COUNT_W = 16;
  localparam int HIGH_W  = 16;
  localparam int REM_W   = 27;
  localparam int QUO_W   = 5;

  // accumulator wrap point and word bases
  localparam logic [SUM_W-1:0] ACC_BASE     = 32'd3000000000;
  localparam logic [SUM_W-1:0] WORD_BASE_SQ = 32'd100000000;
  localparam logic [REM_W-1:0] WORD_BASE    = 27'd10000;

  // top word gains this much per accumulator reduction
  localparam logic [HIGH_W-1:0] HIGH_PER_REDUCTION = 16'd30;

  // largest quotient of a reduced sum by 1e8
  localparam int MAX_QUOTIENT = 29;

  // reciprocal of 10000 scaled by 2^40, exact for values below 1e8
  localparam int                 RECIP_SHIFT = 40;
  localparam logic [REM_W-1:0]   RECIP       = 27'd109951163;
  localparam int                 RPROD_W     = 2 * REM_W;

  // finished sum of one vector with its reduction count
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } rdp_total_t;

endpackage

/* src/radix_10000_digit_dot_product.sv */
// ----------------------------------------------------------------------------
// radix_10000_digit_dot_product
// dot product of base-10000 digit pairs, one result per vector
// ----------------------------------------------------------------------------
// the last pair passes the product, vector total, split remainder, middle word
// and output registers before its result is valid; one pair per cycle, but
// a stalled result holds the whole pipeline until it is taken
// reset: synchronous, clears the accumulator, count and all stage valids
module radix_10000_digit_dot_product
  import rdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DIGIT_W-1:0] in_x_digit,
  input  logic [DIGIT_W-1:0] in_y_digit,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DIGIT_W-1:0] out_low_word,
  output logic [DIGIT_W-1:0] out_mid_word,
  output logic [HIGH_W-1:0]  out_high_word
);

  logic       en;
  logic       total_vld;
  rdp_total_t total;

  // pipeline advances unless a result is waiting
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rdp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid),
    .x_digit   (in_x_digit),
    .y_digit   (in_y_digit),
    .last      (in_last),
    .total_vld (total_vld),
    .total     (total)
  );

  rdp_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .total_vld (total_vld),
    .total     (total),
    .out_vld   (out_valid),
    .low_word  (out_low_word),
    .mid_word  (out_mid_word),
    .high_word (out_high_word)
  );

  // reduced total stays below the wrap point
  a_total_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    total_vld |-> (total.sum < ACC_BASE))
    else $error("accumulated total not reduced");

  // low and middle split words are proper base-10000 digits
  a_words_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_low_word < DIGIT_W'(WORD_BASE)) &&
                   (out_mid_word < DIGIT_W'(WORD_BASE))))
    else $error("output word out of range");

  // no transaction taken while a result is stalled
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken during output stall");

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

/* src/rdp_mac.sv */
// ----------------------------------------------------------------------------
// rdp_mac
// digit multiply stage and reducing accumulator, one pair per cycle while en
// ----------------------------------------------------------------------------
module rdp_mac
  import rdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [DIGIT_W-1:0] x_digit,
  input  logic [DIGIT_W-1:0] y_digit,
  input  logic               last,
  output logic               total_vld,
  output rdp_total_t         total
);

  logic              v1_r;
  logic              last1_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;

  logic [SUM_W-1:0]   acc_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [SUM_W-1:0]   sum_add;
  logic               wrap;
  logic [SUM_W-1:0]   sum_nxt;
  logic [COUNT_W-1:0] cnt_nxt;

  logic       v2_r;
  rdp_total_t total_r;

  // digit product
  assign prod_nxt = {{DIGIT_W{1'b0}}, x_digit} * {{DIGIT_W{1'b0}}, y_digit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      last1_r <= last;
    end
  end

  // accumulate with one conditional reduction
  always_comb begin
    sum_add = acc_r + {{(SUM_W-PROD_W){1'b0}}, prod_r};
    wrap    = (sum_add >= ACC_BASE);
    sum_nxt = wrap ? (sum_add - ACC_BASE) : sum_add;
    cnt_nxt = cnt_r + {{(COUNT_W-1){1'b0}}, wrap};
  end

  // running state, cleared after the last pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (en && v1_r) begin
      if (last1_r) begin
        acc_r <= '0;
        cnt_r <= '0;
      end else begin
        acc_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // finished vector total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r & last1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v1_r && last1_r) begin
      total_r.sum   <= sum_nxt;
      total_r.count <= cnt_nxt;
    end
  end

  assign total_vld = v2_r;
  assign total     = total_r;

endmodule

/* src/rdp_split.sv */
// ----------------------------------------------------------------------------
// rdp_split
// splits a finished total into three base-10000 words over three stages
// ----------------------------------------------------------------------------
module rdp_split
  import rdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               total_vld,
  input  rdp_total_t         total,
  output logic               out_vld,
  output logic [DIGIT_W-1:0] low_word,
  output logic [DIGIT_W-1:0] mid_word,
  output logic [HIGH_W-1:0]  high_word
);

  logic [QUO_W-1:0]  quo;
  logic [SUM_W-1:0]  quo_base;
  logic [SUM_W-1:0]  rem_full;
  logic [HIGH_W-1:0] high_nxt;

  logic              v3_r;
  logic [REM_W-1:0]  rem3_r;
  logic [HIGH_W-1:0] high3_r;

  logic [RPROD_W-1:0] rprod;
  logic               v4_r;
  logic [REM_W-1:0]   rem4_r;
  logic [DIGIT_W-1:0] mid4_r;
  logic [HIGH_W-1:0]  high4_r;

  logic [REM_W-1:0]   low_full;
  logic               out_vld_r;
  logic [DIGIT_W-1:0] low_r;
  logic [DIGIT_W-1:0] mid_r;
  logic [HIGH_W-1:0]  high_r;

  // quotient by 1e8 from parallel threshold compares
  always_comb begin
    quo      = '0;
    quo_base = '0;
    for (int k = 1; k <= MAX_QUOTIENT; k++) begin
      if (total.sum >= (SUM_W'(k) * WORD_BASE_SQ)) begin
        quo      = QUO_W'(k);
        quo_base = SUM_W'(k) * WORD_BASE_SQ;
      end
    end
    rem_full = total.sum - quo_base;
    high_nxt = {{(HIGH_W-QUO_W){1'b0}}, quo} + total.count * HIGH_PER_REDUCTION;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem3_r  <= rem_full[REM_W-1:0];
      high3_r <= high_nxt;
    end
  end

  // middle word by reciprocal multiply
  assign rprod = {{REM_W{1'b0}}, rem3_r} * {{REM_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (en) begin
      rem4_r  <= rem3_r;
      mid4_r  <= rprod[RECIP_SHIFT +: DIGIT_W];
      high4_r <= high3_r;
    end
  end

  // low word is what the middle word leaves
  assign low_full = rem4_r - {{(REM_W-DIGIT_W){1'b0}}, mid4_r} * WORD_BASE;

  always_ff @(posedge clk) begin
    if (en) begin
      low_r  <= low_full[DIGIT_W-1:0];
      mid_r  <= mid4_r;
      high_r <= high4_r;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      v3_r      <= total_vld;
      v4_r      <= v3_r;
      out_vld_r <= v4_r;
    end
  end

  assign out_vld   = out_vld_r;
  assign low_word  = low_r;
  assign mid_word  = mid_r;
  assign high_word = high_r;

endmodule

/* verif/radix_10000_digit_dot_product_tb.sv */
// ----------------------------------------------------------------------------
// radix_10000_digit_dot_product_tb
// self-checking bench for the base-10000 digit dot product
// ----------------------------------------------------------------------------
// a short table of directed pairs opens the run. Random vectors follow, some
// of them long and made of large digits so that the accumulator reduces. A
// vector of maximum digits, sent with no idling on either side, closes the
// run. Every result transaction is compared with typed words or a local
// model of the sum and its reduction count. Both sides idle in random bursts,
// and once the result side holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module radix_10000_digit_dot_product_tb;
  import rdp_pkg::*;

  // run shape
  localparam int RANDOM_PAIRS = 700;
  localparam int LONG_PAIRS   = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int REPORT_MAX   = 10;

  // arithmetic of the model
  localparam logic [31:0] SUM_WRAP  = 32'd3000000000;
  localparam logic [31:0] WORD      = 32'd10000;
  localparam logic [31:0] WORD_SQ   = 32'd100000000;
  localparam logic [31:0] HIGH_STEP = 32'd30;

  localparam logic [DIGIT_W-1:0] DIGIT_TOP = 14'd9999;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 14'd16383;

  typedef struct packed {
    logic [DIGIT_W-1:0] low;
    logic [DIGIT_W-1:0] mid;
    logic [HIGH_W-1:0]  high;
  } dot_words_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] x;
    logic [DIGIT_W-1:0] y;
    logic               last;
    logic [4:0]         reps;
    logic               typed;
    dot_words_t         words;
  } pair_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [DIGIT_W-1:0] in_x_digit;
  logic [DIGIT_W-1:0] in_y_digit;
  logic               in_last;
  logic               out_valid;
  logic               out_ready;
  logic [DIGIT_W-1:0] out_low_word;
  logic [DIGIT_W-1:0] out_mid_word;
  logic [HIGH_W-1:0]  out_high_word;

  // model state and result bookkeeping
  logic [31:0]        acc_sum;
  logic [COUNT_W-1:0] acc_count;
  dot_words_t         pending_words[$];
  dot_words_t         want;
  int                 mismatches;
  int                 results_checked;
  int                 pairs_sent;
  int                 total_reductions;
  int                 cycle_count;

  // side controls
  bit tx_idle;
  bit rx_idle;
  bit hold_req;
  bit hold_done;

  // directed pairs; words are typed in only where they are obvious
  pair_row_t directed_rows [12] = '{
    '{14'd0,     14'd0,     1'b1, 5'd1,  1'b1, '{14'd0,    14'd0,    16'd0}},
    '{DIGIT_TOP, DIGIT_TOP, 1'b1, 5'd1,  1'b1, '{14'd1,    14'd9998, 16'd0}},
    '{DIGIT_MAX, DIGIT_MAX, 1'b1, 5'd1,  1'b1, '{14'd2689, 14'd6840, 16'd2}},
    '{DIGIT_MAX, 14'd0,     1'b0, 5'd1,  1'b0, '{14'd0,    14'd0,    16'd0}},
    '{14'd0,     DIGIT_MAX, 1'b1, 5'd1,  1'b1, '{14'd0,    14'd0,    16'd0}},
    '{14'h2aaa,  14'h1555,  1'b0, 5'd1,  1'b0, '{14'd0,    14'd0,    16'd0}},
    '{14'h1555,  14'h2aaa,  1'b1, 5'd1,  1'b0, '{14'd0,    14'd0,    16'd0}},
    '{14'd1,     14'd1,     1'b0, 5'd1,  1'b0, '{14'd0,    14'd0,    16'd0}},
    '{DIGIT_TOP, 14'd1,     1'b0, 5'd1,  1'b0, '{14'd0,    14'd0,    16'd0}},
    '{14'd1,     DIGIT_TOP, 1'b1, 5'd1,  1'b0, '{14'd0,    14'd0,    16'd0}},
    // twelve maximum products pass the wrap point once
    '{DIGIT_MAX, DIGIT_MAX, 1'b0, 5'd11, 1'b0, '{14'd0,    14'd0,    16'd0}},
    '{DIGIT_MAX, DIGIT_MAX, 1'b1, 5'd1,  1'b0, '{14'd0,    14'd0,    16'd0}}
  };

  radix_10000_digit_dot_product u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x_digit    (in_x_digit),
    .in_y_digit    (in_y_digit),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_low_word  (out_low_word),
    .out_mid_word  (out_mid_word),
    .out_high_word (out_high_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // add one pair to the running sum; on the last pair form the three words
  task automatic fold_pair(input logic [DIGIT_W-1:0] x, input logic [DIGIT_W-1:0] y,
                           input logic last, output bit produced, output dot_words_t w);
    logic [31:0] prod;
    logic [31:0] s;
    logic [31:0] high_full;
    prod = {18'd0, x} * {18'd0, y};
    s = acc_sum + prod;
    if (s >= SUM_WRAP) begin
      s = s - SUM_WRAP;
      acc_count = acc_count + COUNT_W'(1);
      total_reductions++;
    end
    acc_sum = s;
    produced = last;
    w = '0;
    if (last) begin
      high_full = s / WORD_SQ + HIGH_STEP * {16'd0, acc_count};
      w.low  = DIGIT_W'(s % WORD);
      w.mid  = DIGIT_W'((s / WORD) % WORD);
      w.high = high_full[HIGH_W-1:0];
      acc_sum = '0;
      acc_count = '0;
    end
  endtask

  // offer one pair, wait for its transaction, then predict
  task automatic offer_pair(input logic [DIGIT_W-1:0] x, input logic [DIGIT_W-1:0] y,
                            input logic last, input bit typed, input dot_words_t typed_words);
    bit         produced;
    dot_words_t w;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_x_digit <= x;
    in_y_digit <= y;
    in_last    <= last;
    do @(posedge clk); while (!in_ready);
    fold_pair(x, y, last, produced, w);
    if (produced) begin
      pending_words.push_back(typed ? typed_words : w);
    end
    pairs_sent++;
  endtask

  // digit spread over the corners and the whole field
  function automatic logic [DIGIT_W-1:0] any_digit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DIGIT_TOP;
      2: return DIGIT_MAX;
      3: return DIGIT_W'($urandom_range(0, 16383));
      default: return DIGIT_W'($urandom_range(0, 9999));
    endcase
  endfunction

  // large digits so that long vectors pass the wrap point
  function automatic logic [DIGIT_W-1:0] big_digit();
    if ($urandom_range(0, 7) == 0) begin
      return any_digit();
    end
    return DIGIT_W'($urandom_range(12000, 16383));
  endfunction

  // result side: random stalls plus one long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        if (mismatches < REPORT_MAX) begin
          $display("unexpected result: low %0d mid %0d high %0d",
                   out_low_word, out_mid_word, out_high_word);
        end
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        results_checked++;
        if (out_low_word !== want.low || out_mid_word !== want.mid ||
            out_high_word !== want.high) begin
          if (mismatches < REPORT_MAX) begin
            $display("result %0d: expected %0d %0d %0d, got %0d %0d %0d",
                     results_checked, want.low, want.mid, want.high,
                     out_low_word, out_mid_word, out_high_word);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, pending_words.size());
    $display("TB_ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int         start_pairs;
    int         len;
    bit         heavy;
    dot_words_t no_words;
    no_words         = '0;
    acc_sum          = '0;
    acc_count        = '0;
    mismatches       = 0;
    results_checked  = 0;
    pairs_sent       = 0;
    total_reductions = 0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    hold_req         = 1'b0;
    hold_done        = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_x_digit <= '0;
    in_y_digit <= '0;
    in_last    <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      for (int r = 0; r < int'(directed_rows[i].reps); r++) begin
        offer_pair(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].words);
      end
    end

    // random vectors; the result side backs up once at the start
    hold_req = 1'b1;
    start_pairs = pairs_sent;
    while (pairs_sent - start_pairs < RANDOM_PAIRS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      heavy = ($urandom_range(0, 4) == 0);
      len = heavy ? $urandom_range(12, 40) : $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        if (heavy) begin
          offer_pair(big_digit(), big_digit(), k == len - 1, 1'b0, no_words);
        end else begin
          offer_pair(any_digit(), any_digit(), k == len - 1, 1'b0, no_words);
        end
      end
    end

    // one vector of maximum products back to back, no idling
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int k = 0; k < LONG_PAIRS; k++) begin
      offer_pair(DIGIT_MAX, DIGIT_MAX, k == LONG_PAIRS - 1, 1'b0, no_words);
    end
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d pairs and %0d checked results in %0d cycles",
             pairs_sent, results_checked, cycle_count);
    $display("accumulator passed the wrap point %0d times, %0d mismatches",
             total_reductions, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
